// ----- design/battery_energy_balance_gauge_unit_assert.svh -----
// Assertion macros shared by the gauge modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef BATTERY_ENERGY_BALANCE_GAUGE_UNIT_ASSERT_SVH
`define BATTERY_ENERGY_BALANCE_GAUGE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define BEBG_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gauge assertion failed");

// Next-cycle implication.
`define BEBG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gauge assertion failed");

`endif

// ----- design/bebg_pkg.sv -----
package bebg_pkg;

    localparam int EFF_FRAC_BITS_DEF = 16;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam int EFF_W      = 17;
    localparam int CAP_W      = 32;
    localparam int RSV_W      = 7;
    localparam int PWR_W      = 16;
    localparam int DT_W       = 12;
    localparam int LOAD_W     = 19;
    localparam int MARGIN_W   = 20;
    localparam int MAG_W      = 19;
    localparam int ENERGY_W   = 32;
    localparam int SOC_W      = 14;
    localparam int SBP_W      = 16;
    localparam int SECS_W     = 32;

    // Shared multiplier: widest operands are (100*E - C*R) by efficiency
    localparam int MUL_A_W    = 39;
    localparam int MUL_B_W    = 17;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;

    localparam int MDT_W      = MAG_W + DT_W;   // margin * step
    localparam int E100_W     = 39;             // 100 * energy, capacity * reserve
    localparam int MAGX100_W  = 25;             // 100 * margin magnitude
    localparam int SOC_NUM_W  = 46;             // energy * 10000
    localparam int SBP_NUM_W  = 30;             // solar * 10000

    localparam logic [EFF_W-1:0] CHARGE_EFF_RESET    = EFF_W'(58982);
    localparam logic [EFF_W-1:0] DISCHARGE_EFF_RESET = EFF_W'(62259);
    localparam logic [CAP_W-1:0] CAPACITY_RESET      = CAP_W'(36000000);
    localparam logic [RSV_W-1:0] RESERVE_RESET       = RSV_W'(20);

    localparam logic [SOC_W-1:0] BASIS_POINTS  = SOC_W'(10000);
    localparam logic [RSV_W-1:0] PERCENT_SCALE = RSV_W'(100);

    typedef enum logic [1:0] {
        REG_CHARGE_EFF,
        REG_DISCHARGE_EFF,
        REG_CAPACITY,
        REG_RESERVE
    } cfg_reg_t;

    typedef enum logic [2:0] {
        MUL_MDT,    // magnitude * step
        MUL_GAIN,   // (magnitude * step) * charge efficiency
        MUL_SOC,    // energy * 10000
        MUL_SBP,    // solar * 10000
        MUL_E100,   // energy * 100
        MUL_RES,    // capacity * reserve percent
        MUL_DEN,    // magnitude * 100
        MUL_NUM     // reserve headroom * discharge efficiency
    } mul_sel_t;

    typedef enum logic [1:0] {
        DIV_DRAIN,
        DIV_SOC,
        DIV_SBP,
        DIV_SECS
    } div_sel_t;

    typedef struct packed {
        logic     load_item;
        mul_sel_t mul_sel;
        logic     div_start;
        div_sel_t div_sel;
        logic     gain_wr;
        logic     drain_wr;
        logic     soc_wr;
        logic     sbp_wr;
        logic     e100_wr;
        logic     diff_wr;
        logic     den_wr;
        logic     secs_wr;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic deficit;
        logic secs_go;
        logic div_busy;
        logic div_done;
    } dp_stat_t;

endpackage

// ----- design/bebg_div.sv -----
`include "battery_energy_balance_gauge_unit_assert.svh"

// Restoring divider, one quotient bit per cycle. The numerator arrives
// left-aligned; count gives the number of significant numerator bits.
module bebg_div #(
    parameter int NUM_W = 56,
    parameter int DEN_W = 41
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [NUM_W-1:0]           num,
    input  logic [DEN_W-1:0]           den,
    input  logic [$clog2(NUM_W+1)-1:0] count,
    output logic [NUM_W-1:0]           quot,
    output logic                       busy,
    output logic                       done
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quot_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   trial_sub;
    logic             fits;

    always_comb
    begin
        trial     = {rem_reg, quot_reg[NUM_W-1]};
        fits      = (trial >= {1'b0, den_reg});
        trial_sub = trial - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= count;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            quot_reg <= num;
            den_reg  <= den;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
            quot_reg <= {quot_reg[NUM_W-2:0], fits};
        end
    end

    assign quot = quot_reg;
    assign busy = busy_reg;
    assign done = done_reg;

    `BEBG_ASSERT_NEXT(div_start_busy, start, busy_reg)
    `BEBG_ASSERT_IMPL(div_done_idle, done_reg, !busy_reg)

endmodule

// ----- design/bebg_ctrl.sv -----
`include "battery_energy_balance_gauge_unit_assert.svh"

// Sequencer: walks one item through the shared multiplier and divider.
module bebg_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    output bebg_pkg::dp_cmd_t  cmd,
    input  bebg_pkg::dp_stat_t stat
);

    import bebg_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MDT,
        S_GAIN,
        S_GAIN_ADD,
        S_DRAIN_WAIT,
        S_SOC_MUL,
        S_SOC_DIV,
        S_SOC_WAIT,
        S_SBP_MUL,
        S_SBP_DIV,
        S_SBP_WAIT,
        S_E100,
        S_RES,
        S_DIFF,
        S_NUM,
        S_SECS_DIV,
        S_SECS_WAIT,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        cmd         = '0;
        cmd.mul_sel = MUL_MDT;
        cmd.div_sel = DIV_DRAIN;
        state_next  = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_MDT;
                end
            end
            S_MDT:
            begin
                cmd.mul_sel = MUL_MDT;
                state_next  = S_GAIN;
            end
            S_GAIN:
            begin
                if (stat.deficit)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_DRAIN;
                    state_next    = S_DRAIN_WAIT;
                end
                else
                begin
                    cmd.mul_sel = MUL_GAIN;
                    state_next  = S_GAIN_ADD;
                end
            end
            S_GAIN_ADD:
            begin
                cmd.gain_wr = 1'b1;
                state_next  = S_SOC_MUL;
            end
            S_DRAIN_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.drain_wr = 1'b1;
                    state_next   = S_SOC_MUL;
                end
            end
            S_SOC_MUL:
            begin
                cmd.mul_sel = MUL_SOC;
                state_next  = S_SOC_DIV;
            end
            S_SOC_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SOC;
                state_next    = S_SOC_WAIT;
            end
            S_SOC_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.soc_wr = 1'b1;
                    state_next = S_SBP_MUL;
                end
            end
            S_SBP_MUL:
            begin
                cmd.mul_sel = MUL_SBP;
                state_next  = S_SBP_DIV;
            end
            S_SBP_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SBP;
                state_next    = S_SBP_WAIT;
            end
            S_SBP_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.sbp_wr = 1'b1;
                    state_next = S_E100;
                end
            end
            S_E100:
            begin
                cmd.mul_sel = MUL_E100;
                state_next  = S_RES;
            end
            S_RES:
            begin
                cmd.e100_wr = 1'b1;
                cmd.mul_sel = MUL_RES;
                state_next  = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.diff_wr = 1'b1;
                cmd.mul_sel = MUL_DEN;
                state_next  = S_NUM;
            end
            S_NUM:
            begin
                cmd.den_wr  = 1'b1;
                cmd.mul_sel = MUL_NUM;
                state_next  = S_SECS_DIV;
            end
            S_SECS_DIV:
            begin
                if (stat.secs_go)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_SECS;
                    state_next    = S_SECS_WAIT;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_SECS_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.secs_wr = 1'b1;
                    state_next  = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    `BEBG_ASSERT_NEXT(ctrl_accept_then_busy, in_valid && !in_stall, in_stall)
    `BEBG_ASSERT_IMPL(ctrl_div_free, cmd.div_start, !stat.div_busy)

endmodule

// ----- design/bebg_dp.sv -----
`include "battery_energy_balance_gauge_unit_assert.svh"

// Datapath: item registers, shared multiplier, shared divider, working
// registers and the output register.
module bebg_dp #(
    parameter int EFFICIENCY_FRACTION_BITS = bebg_pkg::EFF_FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  bebg_pkg::dp_cmd_t                    cmd,
    output bebg_pkg::dp_stat_t                   stat,
    input  logic [bebg_pkg::EFF_W-1:0]           charge_eff,
    input  logic [bebg_pkg::EFF_W-1:0]           discharge_eff,
    input  logic [bebg_pkg::CAP_W-1:0]           capacity,
    input  logic [bebg_pkg::RSV_W-1:0]           reserve_pct,
    input  logic [bebg_pkg::PWR_W-1:0]           solar_power,
    input  logic [bebg_pkg::PWR_W-1:0]           healthy_solar_power,
    input  logic [bebg_pkg::PWR_W-1:0]           essential_load,
    input  logic [bebg_pkg::PWR_W-1:0]           discretionary_load,
    input  logic [bebg_pkg::PWR_W-1:0]           thermal_load,
    input  logic [bebg_pkg::PWR_W-1:0]           eva_load,
    input  logic [bebg_pkg::PWR_W-1:0]           comms_load,
    input  logic [bebg_pkg::DT_W-1:0]            step_seconds,
    output logic [bebg_pkg::ENERGY_W-1:0]        stored_energy,
    output logic [bebg_pkg::LOAD_W-1:0]          total_load,
    output logic signed [bebg_pkg::MARGIN_W-1:0] power_margin,
    output logic [bebg_pkg::SOC_W-1:0]           charge_basis_points,
    output logic [bebg_pkg::SBP_W-1:0]           solar_basis_points,
    output logic [bebg_pkg::SECS_W-1:0]          seconds_to_reserve,
    output logic                                 reserve_unbounded
);

    import bebg_pkg::*;

    localparam int F         = EFFICIENCY_FRACTION_BITS;
    localparam int DIV_NUM_W = (MDT_W + F > PROD_W) ? MDT_W + F : PROD_W;
    localparam int DIV_DEN_W = (MAGX100_W + F > CAP_W) ? MAGX100_W + F : CAP_W;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    // item registers
    logic [PWR_W-1:0]    solar_reg;
    logic [PWR_W-1:0]    healthy_reg;
    logic [DT_W-1:0]     dt_reg;
    logic [LOAD_W-1:0]   load_reg;
    logic [MAG_W-1:0]    mag_reg;
    logic [MARGIN_W-1:0] margin_reg;
    logic                deficit_reg;

    logic [LOAD_W-1:0]   load_sum;
    logic                deficit_now;
    logic [MAG_W-1:0]    mag_now;

    // working registers
    logic [PROD_W-1:0]    prod_reg;
    logic [ENERGY_W-1:0]  energy_reg;
    logic [E100_W-1:0]    e100_reg;
    logic [E100_W-1:0]    diff_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic                 go_reg;
    logic [SOC_W-1:0]     soc_reg;
    logic [SBP_W-1:0]     sbp_reg;
    logic [SECS_W-1:0]    secs_reg;

    // output register
    logic [ENERGY_W-1:0]  out_energy_reg;
    logic [LOAD_W-1:0]    out_load_reg;
    logic [MARGIN_W-1:0]  out_margin_reg;
    logic [SOC_W-1:0]     out_soc_reg;
    logic [SBP_W-1:0]     out_sbp_reg;
    logic [SECS_W-1:0]    out_secs_reg;
    logic                 out_unb_reg;

    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic [PROD_W-1:0]    prod_next;
    logic [EFF_W-1:0]     de_eff;

    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic [DIV_CNT_W-1:0] div_cnt;
    logic [DIV_NUM_W-1:0] quot;
    logic                 div_busy;
    logic                 div_done;

    logic [PROD_W:0]      gain_sum;
    logic [ENERGY_W-1:0]  energy_gain;
    logic [ENERGY_W-1:0]  energy_drained;
    logic [ENERGY_W-1:0]  energy_drain;
    logic [ENERGY_W-1:0]  energy_next;
    logic [E100_W-1:0]    res_val;

    // loads, margin and its sign
    always_comb
    begin
        load_sum    = LOAD_W'(essential_load) + LOAD_W'(discretionary_load)
                    + LOAD_W'(thermal_load) + LOAD_W'(eva_load) + LOAD_W'(comms_load);
        deficit_now = (load_sum > LOAD_W'(solar_power));
        mag_now     = deficit_now ? (load_sum - LOAD_W'(solar_power))
                                  : (LOAD_W'(solar_power) - load_sum);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            solar_reg   <= solar_power;
            healthy_reg <= healthy_solar_power;
            dt_reg      <= step_seconds;
            load_reg    <= load_sum;
            mag_reg     <= mag_now;
            deficit_reg <= deficit_now;
            margin_reg  <= deficit_now ? (MARGIN_W'(0) - MARGIN_W'(mag_now))
                                       : MARGIN_W'(mag_now);
        end
    end

    assign de_eff = (discharge_eff == '0) ? EFF_W'(1) : discharge_eff;

    // shared multiplier, product registered every cycle
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_MDT:
            begin
                mul_a = MUL_A_W'(mag_reg);
                mul_b = MUL_B_W'(dt_reg);
            end
            MUL_GAIN:
            begin
                mul_a = MUL_A_W'(prod_reg[MDT_W-1:0]);
                mul_b = MUL_B_W'(charge_eff);
            end
            MUL_SOC:
            begin
                mul_a = MUL_A_W'(energy_reg);
                mul_b = MUL_B_W'(BASIS_POINTS);
            end
            MUL_SBP:
            begin
                mul_a = MUL_A_W'(solar_reg);
                mul_b = MUL_B_W'(BASIS_POINTS);
            end
            MUL_E100:
            begin
                mul_a = MUL_A_W'(energy_reg);
                mul_b = MUL_B_W'(PERCENT_SCALE);
            end
            MUL_RES:
            begin
                mul_a = MUL_A_W'(capacity);
                mul_b = MUL_B_W'(reserve_pct);
            end
            MUL_DEN:
            begin
                mul_a = MUL_A_W'(mag_reg);
                mul_b = MUL_B_W'(PERCENT_SCALE);
            end
            MUL_NUM:
            begin
                mul_a = diff_reg;
                mul_b = MUL_B_W'(de_eff);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // divider operands: numerator left-aligned, count = its significant bits
    always_comb
    begin
        case (cmd.div_sel)
            DIV_DRAIN:
            begin
                div_num = DIV_NUM_W'(prod_reg[MDT_W-1:0]) << (DIV_NUM_W - MDT_W);
                div_den = DIV_DEN_W'(de_eff);
                div_cnt = DIV_CNT_W'(MDT_W + F);
            end
            DIV_SOC:
            begin
                div_num = DIV_NUM_W'(prod_reg[SOC_NUM_W-1:0]) << (DIV_NUM_W - SOC_NUM_W);
                div_den = DIV_DEN_W'(capacity);
                div_cnt = DIV_CNT_W'(SOC_NUM_W);
            end
            DIV_SBP:
            begin
                div_num = DIV_NUM_W'(prod_reg[SBP_NUM_W-1:0]) << (DIV_NUM_W - SBP_NUM_W);
                div_den = DIV_DEN_W'(healthy_reg);
                div_cnt = DIV_CNT_W'(SBP_NUM_W);
            end
            DIV_SECS:
            begin
                div_num = DIV_NUM_W'(prod_reg) << (DIV_NUM_W - PROD_W);
                div_den = den_reg;
                div_cnt = DIV_CNT_W'(PROD_W);
            end
            default:
            begin
                div_num = '0;
                div_den = '0;
                div_cnt = '0;
            end
        endcase
    end

    bebg_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .count (div_cnt),
        .quot  (quot),
        .busy  (div_busy),
        .done  (div_done)
    );

    // energy update and clamp
    always_comb
    begin
        gain_sum       = (PROD_W+1)'(prod_reg >> F) + (PROD_W+1)'(energy_reg);
        energy_gain    = (gain_sum > (PROD_W+1)'(capacity)) ? capacity
                                                            : gain_sum[ENERGY_W-1:0];
        energy_drained = (DIV_NUM_W'(energy_reg) > quot)
                       ? (energy_reg - quot[ENERGY_W-1:0]) : '0;
        energy_drain   = (energy_drained > capacity) ? capacity : energy_drained;
        energy_next    = cmd.gain_wr ? energy_gain : energy_drain;
        res_val        = prod_reg[E100_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            energy_reg <= '0;
        end
        else if (cmd.gain_wr || cmd.drain_wr)
        begin
            energy_reg <= energy_next;
        end
    end

    // telemetry working registers
    always_ff @(posedge clk)
    begin
        if (cmd.soc_wr)
        begin
            soc_reg <= (capacity == '0) ? '0 : quot[SOC_W-1:0];
        end
        if (cmd.sbp_wr)
        begin
            if (healthy_reg == '0)
            begin
                sbp_reg <= '0;
            end
            else
            begin
                sbp_reg <= (|quot[DIV_NUM_W-1:SBP_W]) ? '1 : quot[SBP_W-1:0];
            end
        end
        if (cmd.e100_wr)
        begin
            e100_reg <= prod_reg[E100_W-1:0];
        end
        if (cmd.diff_wr)
        begin
            diff_reg <= e100_reg - res_val;
            go_reg   <= deficit_reg && (e100_reg > res_val);
            secs_reg <= '0;
        end
        else if (cmd.secs_wr)
        begin
            secs_reg <= (|quot[DIV_NUM_W-1:SECS_W]) ? '1 : quot[SECS_W-1:0];
        end
        if (cmd.den_wr)
        begin
            den_reg <= DIV_DEN_W'(prod_reg[MAGX100_W-1:0]) << F;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_energy_reg <= energy_reg;
            out_load_reg   <= load_reg;
            out_margin_reg <= margin_reg;
            out_soc_reg    <= soc_reg;
            out_sbp_reg    <= sbp_reg;
            out_secs_reg   <= secs_reg;
            out_unb_reg    <= !go_reg;
        end
    end

    assign stored_energy       = out_energy_reg;
    assign total_load          = out_load_reg;
    assign power_margin        = out_margin_reg;
    assign charge_basis_points = out_soc_reg;
    assign solar_basis_points  = out_sbp_reg;
    assign seconds_to_reserve  = out_secs_reg;
    assign reserve_unbounded   = out_unb_reg;

    assign stat.deficit  = deficit_reg;
    assign stat.secs_go  = go_reg;
    assign stat.div_busy = div_busy;
    assign stat.div_done = div_done;

    `BEBG_ASSERT_NEXT(dp_energy_capped, cmd.gain_wr || cmd.drain_wr, energy_reg <= capacity)

endmodule

// ----- design/battery_energy_balance_gauge_unit.sv -----
// Battery energy-counting gauge.
// Input channel (in_valid/in_stall): one item per simulation step carrying
// solar and healthy solar power, five loads and the step length. Output
// channel (out_valid/out_stall): one item per input with the updated stored
// energy, load total, signed margin, charge and solar basis points and the
// seconds left until the reserve level.
// Each division runs through one shared restoring divider at one quotient
// bit per cycle. One item is in work at a time, so the next item is taken
// the cycle after a result enters the output stage.
// A finished item sits in the output register while the next one is worked;
// if the receiver still stalls when the following result is ready, the
// sequencer holds in its last step and in_stall stays high.
// Reset clears the stored energy to zero, empties the output stage and loads
// the register defaults. Registers (APB, 4-byte spaced) may be written only
// while no item is in work.
module battery_energy_balance_gauge_unit #(
    parameter int EFFICIENCY_FRACTION_BITS = bebg_pkg::EFF_FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bebg_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [bebg_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [bebg_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                 pready,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [bebg_pkg::PWR_W-1:0]           solar_power,
    input  logic [bebg_pkg::PWR_W-1:0]           healthy_solar_power,
    input  logic [bebg_pkg::PWR_W-1:0]           essential_load,
    input  logic [bebg_pkg::PWR_W-1:0]           discretionary_load,
    input  logic [bebg_pkg::PWR_W-1:0]           thermal_load,
    input  logic [bebg_pkg::PWR_W-1:0]           eva_load,
    input  logic [bebg_pkg::PWR_W-1:0]           comms_load,
    input  logic [bebg_pkg::DT_W-1:0]            step_seconds,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [bebg_pkg::ENERGY_W-1:0]        stored_energy,
    output logic [bebg_pkg::LOAD_W-1:0]          total_load,
    output logic signed [bebg_pkg::MARGIN_W-1:0] power_margin,
    output logic [bebg_pkg::SOC_W-1:0]           charge_basis_points,
    output logic [bebg_pkg::SBP_W-1:0]           solar_basis_points,
    output logic [bebg_pkg::SECS_W-1:0]          seconds_to_reserve,
    output logic                                 reserve_unbounded
);

    import bebg_pkg::*;

    logic [EFF_W-1:0] charge_eff_reg;
    logic [EFF_W-1:0] discharge_eff_reg;
    logic [CAP_W-1:0] capacity_reg;
    logic [RSV_W-1:0] reserve_reg;

    logic     cfg_wr;
    cfg_reg_t cfg_sel;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // register file: word index from the address, byte offset ignored
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = cfg_reg_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            charge_eff_reg    <= CHARGE_EFF_RESET;
            discharge_eff_reg <= DISCHARGE_EFF_RESET;
            capacity_reg      <= CAPACITY_RESET;
            reserve_reg       <= RESERVE_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                REG_CHARGE_EFF:    charge_eff_reg    <= pwdata[EFF_W-1:0];
                REG_DISCHARGE_EFF: discharge_eff_reg <= pwdata[EFF_W-1:0];
                REG_CAPACITY:      capacity_reg      <= pwdata[CAP_W-1:0];
                REG_RESERVE:       reserve_reg       <= pwdata[RSV_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_CHARGE_EFF:    prdata = CFG_DATA_W'(charge_eff_reg);
            REG_DISCHARGE_EFF: prdata = CFG_DATA_W'(discharge_eff_reg);
            REG_CAPACITY:      prdata = CFG_DATA_W'(capacity_reg);
            REG_RESERVE:       prdata = CFG_DATA_W'(reserve_reg);
            default:           prdata = '0;
        endcase
    end

    // sequencer
    bebg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    // arithmetic
    bebg_dp #(
        .EFFICIENCY_FRACTION_BITS (EFFICIENCY_FRACTION_BITS)
    ) u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .stat                (stat),
        .charge_eff          (charge_eff_reg),
        .discharge_eff       (discharge_eff_reg),
        .capacity            (capacity_reg),
        .reserve_pct         (reserve_reg),
        .solar_power         (solar_power),
        .healthy_solar_power (healthy_solar_power),
        .essential_load      (essential_load),
        .discretionary_load  (discretionary_load),
        .thermal_load        (thermal_load),
        .eva_load            (eva_load),
        .comms_load          (comms_load),
        .step_seconds        (step_seconds),
        .stored_energy       (stored_energy),
        .total_load          (total_load),
        .power_margin        (power_margin),
        .charge_basis_points (charge_basis_points),
        .solar_basis_points  (solar_basis_points),
        .seconds_to_reserve  (seconds_to_reserve),
        .reserve_unbounded   (reserve_unbounded)
    );

endmodule

// ----- bench/tb.sv -----
module tb;
    import bebg_pkg::*;

    // Q1.F efficiency scaling, as built into the default instance
    localparam int FRAC_BITS     = EFF_FRAC_BITS_DEF;
    // cycles with no accepted item, reading or register access before giving up
    localparam int QUIET_LIMIT   = 6000;
    // time to let pass at the end, beyond the slowest item
    localparam int SETTLE_CYCLES = 250;

    typedef struct {
        bit [PWR_W-1:0] solar, healthy, essential, discretionary, thermal, eva, comms;
        bit [DT_W-1:0]  dt;
    } gauge_item_t;

    typedef struct {
        bit [ENERGY_W-1:0] energy;
        bit [LOAD_W-1:0]   load;
        bit [MARGIN_W-1:0] margin;
        bit [SOC_W-1:0]    soc;
        bit [SBP_W-1:0]    sbp;
        bit [SECS_W-1:0]   secs;
        bit                unbounded;
    } gauge_reading_t;

    // random item mixes
    typedef enum int {
        SHAPE_NOISE,        // every field uniform, mostly a heavy deficit
        SHAPE_CHARGE,       // strong sun, light loads
        SHAPE_MILD_DRAIN,   // small deficit over short steps: keeps energy above reserve
        SHAPE_CORNER        // field extremes
    } item_shape_t;

    logic                       clk     = 1'b0;
    logic                       rst_n   = 1'b0;
    logic                       psel    = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0]      paddr   = '0;
    logic [CFG_DATA_W-1:0]      pwdata  = '0;
    logic [CFG_DATA_W-1:0]      prdata;
    logic                       pready;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [PWR_W-1:0]           solar_power         = '0;
    logic [PWR_W-1:0]           healthy_solar_power = '0;
    logic [PWR_W-1:0]           essential_load      = '0;
    logic [PWR_W-1:0]           discretionary_load  = '0;
    logic [PWR_W-1:0]           thermal_load        = '0;
    logic [PWR_W-1:0]           eva_load            = '0;
    logic [PWR_W-1:0]           comms_load          = '0;
    logic [DT_W-1:0]            step_seconds        = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [ENERGY_W-1:0]        stored_energy;
    logic [LOAD_W-1:0]          total_load;
    logic signed [MARGIN_W-1:0] power_margin;
    logic [SOC_W-1:0]           charge_basis_points;
    logic [SBP_W-1:0]           solar_basis_points;
    logic [SECS_W-1:0]          seconds_to_reserve;
    logic                       reserve_unbounded;

    // Gauge state as the bench sees it: registers plus the battery energy
    bit [EFF_W-1:0]    chg_eff     = CHARGE_EFF_RESET;
    bit [EFF_W-1:0]    dis_eff     = DISCHARGE_EFF_RESET;
    bit [CAP_W-1:0]    capacity_j  = CAPACITY_RESET;
    bit [RSV_W-1:0]    reserve_pct = RESERVE_RESET;
    bit [ENERGY_W-1:0] energy_j    = '0;

    // readings owed by the block, oldest first
    gauge_reading_t readings_due[$];

    int mismatches        = 0;
    int items_sent        = 0;
    int readings_checked  = 0;
    int finite_reserve    = 0;
    int saturated_reserve = 0;
    int settings_loaded   = 0;

    // pacing knobs, in percent per cycle
    int gap_pct     = 0;
    int stall_pct   = 0;
    int stall_burst = 0;
    int quiet_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    battery_energy_balance_gauge_unit dut (.*);

    // ------------------------------------------------------------------
    // Energy integration and telemetry for one item, exact integer maths.
    // Advances energy_j, so call once per accepted item, in order.
    // ------------------------------------------------------------------
    function automatic gauge_reading_t predict_reading(gauge_item_t it);
        bit [63:0]      load, mag, eff_div, e, drain, gain, quot, reserve100, headroom;
        bit             deficit;
        gauge_reading_t r;
        load = 64'(it.essential) + 64'(it.discretionary) + 64'(it.thermal)
             + 64'(it.eva) + 64'(it.comms);
        deficit = load > 64'(it.solar);
        mag = deficit ? load - 64'(it.solar) : 64'(it.solar) - load;
        // a zero discharge efficiency behaves as the smallest step
        eff_div = (dis_eff == '0) ? 64'd1 : 64'(dis_eff);
        e = 64'(energy_j);
        if (deficit)
        begin
            drain = ((mag * 64'(it.dt)) << FRAC_BITS) / eff_div;
            e = (e > drain) ? e - drain : 64'd0;
        end
        else
        begin
            gain = (mag * 64'(it.dt) * 64'(chg_eff)) >> FRAC_BITS;
            e = e + gain;
        end
        // clamp also catches energy left above a newly lowered capacity
        if (e > 64'(capacity_j))
            e = 64'(capacity_j);
        energy_j = e[ENERGY_W-1:0];

        r.energy = energy_j;
        r.load   = load[LOAD_W-1:0];
        r.margin = deficit ? MARGIN_W'(64'd0 - mag) : mag[MARGIN_W-1:0];

        r.soc = '0;
        if (capacity_j != '0)
        begin
            quot  = (e * 64'(BASIS_POINTS)) / 64'(capacity_j);
            r.soc = quot[SOC_W-1:0];
        end
        r.sbp = '0;
        if (it.healthy != '0)
        begin
            quot  = (64'(it.solar) * 64'(BASIS_POINTS)) / 64'(it.healthy);
            r.sbp = (quot > 64'(16'hFFFF)) ? '1 : quot[SBP_W-1:0];
        end

        r.secs      = '0;
        r.unbounded = 1'b1;
        reserve100  = 64'(capacity_j) * 64'(reserve_pct);
        if (deficit && e * 64'(PERCENT_SCALE) > reserve100)
        begin
            headroom    = e * 64'(PERCENT_SCALE) - reserve100;
            quot        = (headroom * eff_div) / ((64'(PERCENT_SCALE) * mag) << FRAC_BITS);
            r.secs      = (quot > 64'hFFFF_FFFF) ? '1 : quot[SECS_W-1:0];
            r.unbounded = 1'b0;
        end
        return r;
    endfunction

    function automatic gauge_item_t make_item(int s, int h, int ess, int disc, int therm,
                                              int eva, int comms, int dt);
        gauge_item_t it;
        it.solar         = s[PWR_W-1:0];
        it.healthy       = h[PWR_W-1:0];
        it.essential     = ess[PWR_W-1:0];
        it.discretionary = disc[PWR_W-1:0];
        it.thermal       = therm[PWR_W-1:0];
        it.eva           = eva[PWR_W-1:0];
        it.comms         = comms[PWR_W-1:0];
        it.dt            = dt[DT_W-1:0];
        return it;
    endfunction

    function automatic int corner_power();
        case ($urandom_range(3))
            0: return 0;
            1: return 1;
            2: return 65535;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic gauge_item_t random_item();
        item_shape_t shape;
        int          pick;
        int          dts[4];
        pick = $urandom_range(99);
        dts  = '{0, 1, 3600, 4095};
        if (pick < 25)      shape = SHAPE_NOISE;
        else if (pick < 60) shape = SHAPE_CHARGE;
        else if (pick < 90) shape = SHAPE_MILD_DRAIN;
        else                shape = SHAPE_CORNER;
        case (shape)
            SHAPE_NOISE:
                return make_item($urandom_range(0, 65535), $urandom_range(0, 65535),
                                 $urandom_range(0, 65535), $urandom_range(0, 65535),
                                 $urandom_range(0, 65535), $urandom_range(0, 65535),
                                 $urandom_range(0, 65535), $urandom_range(0, 4095));
            SHAPE_CHARGE:
                return make_item($urandom_range(1000, 65535), $urandom_range(0, 65535),
                                 $urandom_range(0, 150), $urandom_range(0, 150),
                                 $urandom_range(0, 150), $urandom_range(0, 150),
                                 $urandom_range(0, 150), $urandom_range(0, 3600));
            SHAPE_MILD_DRAIN:
                return make_item($urandom_range(0, 2000), $urandom_range(0, 65535),
                                 $urandom_range(0, 600), $urandom_range(0, 600),
                                 $urandom_range(0, 600), $urandom_range(0, 600),
                                 $urandom_range(0, 600), $urandom_range(0, 60));
            default:
                return make_item(corner_power(), corner_power(), corner_power(),
                                 corner_power(), corner_power(), corner_power(),
                                 corner_power(), dts[$urandom_range(3)]);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input side. Valid stays up after an accepted item, so whoever runs
    // next either lowers it or presents the next item, never both in one
    // step.
    // ------------------------------------------------------------------
    task automatic send_item(gauge_item_t it);
        int gap;
        gap = 0;
        // now and then a long gap, so the next item lands at any point of
        // the block's own work or the output hold
        if (gap_pct != 0 && $urandom_range(15) == 0)
            gap = $urandom_range(1, 250);
        else
            while ($urandom_range(99) < gap_pct)
                gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        solar_power         <= it.solar;
        healthy_solar_power <= it.healthy;
        essential_load      <= it.essential;
        discretionary_load  <= it.discretionary;
        thermal_load        <= it.thermal;
        eva_load            <= it.eva;
        comms_load          <= it.comms;
        step_seconds        <= it.dt;
        in_valid            <= 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        readings_due = {readings_due, predict_reading(it)};
        items_sent++;
    endtask

    // Stop sending and hold off until every owed reading has come back.
    // Always waits on the clock before checking, so valid is free again after.
    task automatic drain_readings();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (readings_due.size() != 0);
    endtask

    task automatic apb_transfer(bit wr, cfg_reg_t idx, bit [CFG_DATA_W-1:0] wdata,
                                output logic [CFG_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= CFG_ADDR_W'(idx) << 2;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Register write with read-back; only ever done with the block idle.
    task automatic cfg_write(cfg_reg_t idx, bit [CFG_DATA_W-1:0] val);
        logic [CFG_DATA_W-1:0] rd;
        logic [CFG_DATA_W-1:0] want;
        drain_readings();
        apb_transfer(1'b1, idx, val, rd);
        case (idx)
            REG_CHARGE_EFF:
            begin
                chg_eff = val[EFF_W-1:0];
                want    = CFG_DATA_W'(chg_eff);
            end
            REG_DISCHARGE_EFF:
            begin
                dis_eff = val[EFF_W-1:0];
                want    = CFG_DATA_W'(dis_eff);
            end
            REG_CAPACITY:
            begin
                capacity_j = val[CAP_W-1:0];
                want       = CFG_DATA_W'(capacity_j);
            end
            default:
            begin
                reserve_pct = val[RSV_W-1:0];
                want        = CFG_DATA_W'(reserve_pct);
            end
        endcase
        apb_transfer(1'b0, idx, '0, rd);
        if (rd !== want)
        begin
            mismatches++;
            $display("%0t: read-back of %s expected %0d got %0d", $time, idx.name(), want, rd);
        end
    endtask

    task automatic load_settings(bit [31:0] ce, bit [31:0] de, bit [31:0] cap, bit [31:0] rsv);
        cfg_write(REG_CHARGE_EFF, ce);
        cfg_write(REG_DISCHARGE_EFF, de);
        cfg_write(REG_CAPACITY, cap);
        cfg_write(REG_RESERVE, rsv);
        settings_loaded++;
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall, with the odd long burst so a finished
    // reading sits in the output stage while the next one is worked.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (stall_burst != 0)
        begin
            stall_burst--;
            out_stall <= 1'b1;
        end
        else if (stall_pct != 0 && $urandom_range(999) < 4)
        begin
            stall_burst = $urandom_range(20, 300);
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %0d got %0d", $time, what, want, got);
        end
    endtask

    // every accepted reading against the oldest one owed
    always @(posedge clk)
    begin
        gauge_reading_t want;
        if (out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (readings_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: reading with no item outstanding, energy %0d", $time,
                         stored_energy);
            end
            else
            begin
                want = readings_due[0];
                readings_due.delete(0);
                readings_checked++;
                check_field("stored_energy", want.energy, stored_energy);
                check_field("total_load", want.load, total_load);
                // margin compared as its 20-bit two's complement pattern
                check_field("power_margin", want.margin, $unsigned(power_margin));
                check_field("charge_basis_points", want.soc, charge_basis_points);
                check_field("solar_basis_points", want.sbp, solar_basis_points);
                check_field("seconds_to_reserve", want.secs, seconds_to_reserve);
                check_field("reserve_unbounded", want.unbounded, reserve_unbounded);
                if (!want.unbounded)
                    finite_reserve++;
                if (!want.unbounded && want.secs == '1)
                    saturated_reserve++;
            end
        end
    end

    // watchdog: any accepted item, reading or register access counts as progress
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (in_valid === 1'b1 && in_stall === 1'b0)
            || (out_valid === 1'b1 && out_stall === 1'b0) || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed checks
    // ------------------------------------------------------------------

    // Straight out of reset: empty battery, default registers.
    // Idle item, full sun to the capacity clamp with solar ratio saturating,
    // then every load at full scale with the longest step.
    task automatic test_reset_state();
        send_item(make_item(0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(65535, 1, 0, 0, 0, 0, 0, 4095));
        send_item(make_item(0, 65535, 65535, 65535, 65535, 65535, 65535, 4095));
    endtask

    // Zero capacity pins energy and charge reading at zero.
    task automatic test_zero_capacity();
        cfg_write(REG_CAPACITY, 0);
        send_item(make_item(65535, 65535, 0, 0, 0, 0, 0, 3600));
        send_item(make_item(0, 1000, 100, 100, 100, 100, 100, 10));
        cfg_write(REG_CAPACITY, CAPACITY_RESET);
    endtask

    // Zero discharge efficiency acts as the smallest nonzero value, both in
    // the drain and in the time-to-reserve figure.
    task automatic test_zero_discharge_efficiency();
        cfg_write(REG_DISCHARGE_EFF, 0);
        send_item(make_item(65535, 40000, 0, 0, 0, 0, 0, 3600));
        send_item(make_item(0, 40000, 1, 0, 0, 0, 0, 1));
        cfg_write(REG_DISCHARGE_EFF, DISCHARGE_EFF_RESET);
    endtask

    // Energy above a newly lowered capacity is clipped even on a zero step.
    task automatic test_lowered_capacity();
        cfg_write(REG_CAPACITY, 1000);
        send_item(make_item(0, 500, 500, 0, 0, 0, 0, 0));
        send_item(make_item(700, 500, 0, 0, 0, 0, 0, 0));
    endtask

    // Reserve at or beyond the whole battery: time to reserve never bounded.
    task automatic test_reserve_above_full();
        cfg_write(REG_CAPACITY, CAPACITY_RESET);
        cfg_write(REG_RESERVE, 127);
        send_item(make_item(65535, 65535, 0, 0, 0, 0, 0, 3600));
        send_item(make_item(0, 100, 5000, 0, 0, 0, 0, 10));
        cfg_write(REG_RESERVE, 100);
        send_item(make_item(65535, 65535, 0, 0, 0, 0, 0, 3600));
        send_item(make_item(0, 100, 0, 0, 0, 0, 1, 0));
    endtask

    // Largest efficiencies and capacity with zero reserve, battery filled to the top, then a one-watt deficit:
    // the seconds figure overflows 32 bits and must saturate.
    task automatic test_reserve_time_saturation();
        load_settings(131071, 131071, 32'hFFFF_FFFF, 0);
        repeat (9)
            send_item(make_item(65535, 65535, 0, 0, 0, 0, 0, 4095));
        send_item(make_item(0, 65535, 0, 0, 0, 0, 1, 0));
    endtask

    // ------------------------------------------------------------------
    // Random traffic under one pacing mix. Every so often the sender waits
    // for the block to empty out completely before going on.
    // ------------------------------------------------------------------
    task automatic test_random_traffic(int idle_gap, int idle_stall, int count);
        gap_pct   = idle_gap;
        stall_pct = idle_stall;
        for (int i = 0; i < count; i++)
        begin
            if (i != 0 && i % 60 == 0)
                drain_readings();
            send_item(random_item());
        end
        drain_readings();
        gap_pct   = 0;
        stall_pct = 0;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_zero_capacity();
        test_zero_discharge_efficiency();
        test_lowered_capacity();
        test_reserve_above_full();
        test_reserve_time_saturation();

        // defaults, no idling on either side
        load_settings(CHARGE_EFF_RESET, DISCHARGE_EFF_RESET, CAPACITY_RESET, RESERVE_RESET);
        test_random_traffic(0, 0, 110);
        // lossless conversion, widest capacity, sender idling
        load_settings(65536, 65536, 32'hFFFF_FFFF, 50);
        test_random_traffic(46, 0, 115);
        // weakest charging, small battery, receiver stalling
        load_settings(1, 131071, $urandom_range(10000, 100000), 0);
        test_random_traffic(0, 46, 110);
        // random registers, both sides idling
        load_settings($urandom_range(1, 131071), $urandom_range(0, 131071), $urandom,
                      $urandom_range(0, 127));
        test_random_traffic(17, 17, 115);

        drain_readings();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d items, %0d readings, %0d with a finite reserve time (%0d at max),",
                 items_sent, readings_checked, finite_reserve, saturated_reserve);
        $display("over %0d register sets and four mixes of input gaps and output stalls.",
                 settings_loaded);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/bebg_pkg.sv
design/bebg_div.sv
design/bebg_ctrl.sv
design/bebg_dp.sv
design/battery_energy_balance_gauge_unit.sv
bench/tb.sv
